// ===== rtl/pps_pkg.sv =====
// Shared types, register indexes and codes for the power policy selector.
package pps_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [2:0] {
    REG_USER_MODE        = 3'd0,
    REG_LOW_BAT_PERCENT  = 3'd1,
    REG_BAT_FREQ_CAP     = 3'd2,
    REG_LOW_BAT_FREQ_CAP = 3'd3,
    REG_CUSTOM_ALLOW     = 3'd4,
    REG_CUSTOM_RPM_AGGR  = 3'd5,
    REG_WIFI_MANAGED     = 3'd6,
    REG_AUDIO_MANAGED    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_MAX_BATTERY = 2'd0,
    MODE_BALANCED    = 2'd1,
    MODE_PERFORMANCE = 2'd2,
    MODE_CUSTOM      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    GS_POWERSAVE   = 2'd0,
    GS_BALANCED    = 2'd1,
    GS_PERFORMANCE = 2'd2,
    GS_OTHER       = 2'd3
  } gov_state_t;

  typedef enum logic [1:0] {
    GOV_POWERSAVE   = 2'd0,
    GOV_SCHEDUTIL   = 2'd1,
    GOV_PERFORMANCE = 2'd2
  } gov_sel_t;

  typedef enum logic [2:0] {
    EPP_POWER       = 3'd0,
    EPP_BAL_POWER   = 3'd1,
    EPP_BAL_PERF    = 3'd2,
    EPP_PERFORMANCE = 3'd3,
    EPP_DEFAULT     = 3'd4
  } epp_t;

  typedef enum logic [1:0] {
    PROF_LOW_POWER   = 2'd0,
    PROF_BALANCED    = 2'd1,
    PROF_PERFORMANCE = 2'd2
  } profile_t;

  localparam logic [1:0] AggrMax   = 2'd3;
  localparam logic [1:0] AggrHigh  = 2'd2;
  localparam logic [1:0] AggrLow   = 2'd1;
  localparam logic [1:0] AggrNone  = 2'd0;

  localparam logic [1:0] PeriphOff  = 2'd0;
  localparam logic [1:0] PeriphLow  = 2'd1;
  localparam logic [1:0] PeriphHigh = 2'd2;

  typedef struct packed {
    mode_t      op_mode;
    logic [6:0] low_battery_percent;
    logic [6:0] battery_freq_cap;
    logic [6:0] low_battery_freq_cap;
    logic       custom_allow_perf;
    logic       custom_runtime_aggr;
    logic       wifi_managed;
    logic       audio_managed;
  } cfg_t;

  typedef struct packed {
    logic             supply_present;
    logic             source_battery;
    logic signed [7:0] capacity_percent;
    gov_state_t       governor_state;
    logic             perf_limited;
  } status_t;

  typedef struct packed {
    gov_sel_t   governor_sel;
    epp_t       energy_pref;
    logic       turbo_enable;
    logic       perf_allowed;
    logic [6:0] freq_cap_percent;
    profile_t   sys_profile;
    logic       runtime_pm_aggr;
    logic [1:0] dev_aggr_level;
    logic [1:0] periph_pm_lvl;
  } policy_t;

endpackage

// ===== rtl/pps_regs.sv =====
// Configuration register file behind the APB-style port.
module pps_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pps_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [pps_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [pps_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output pps_pkg::cfg_t                cfg
);

  pps_pkg::cfg_t      cfg_r;
  pps_pkg::reg_idx_t  idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = pps_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.op_mode              <= pps_pkg::MODE_BALANCED;
      cfg_r.low_battery_percent  <= 7'd15;
      cfg_r.battery_freq_cap     <= 7'd0;
      cfg_r.low_battery_freq_cap <= 7'd50;
      cfg_r.custom_allow_perf    <= 1'b0;
      cfg_r.custom_runtime_aggr  <= 1'b0;
      cfg_r.wifi_managed         <= 1'b0;
      cfg_r.audio_managed        <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        pps_pkg::REG_USER_MODE:
          cfg_r.op_mode <= pps_pkg::mode_t'(cfg_pwdata[1:0]);
        pps_pkg::REG_LOW_BAT_PERCENT:  cfg_r.low_battery_percent  <= cfg_pwdata[6:0];
        pps_pkg::REG_BAT_FREQ_CAP:     cfg_r.battery_freq_cap     <= cfg_pwdata[6:0];
        pps_pkg::REG_LOW_BAT_FREQ_CAP: cfg_r.low_battery_freq_cap <= cfg_pwdata[6:0];
        pps_pkg::REG_CUSTOM_ALLOW:     cfg_r.custom_allow_perf    <= cfg_pwdata[0];
        pps_pkg::REG_CUSTOM_RPM_AGGR:  cfg_r.custom_runtime_aggr  <= cfg_pwdata[0];
        pps_pkg::REG_WIFI_MANAGED:     cfg_r.wifi_managed         <= cfg_pwdata[0];
        pps_pkg::REG_AUDIO_MANAGED:    cfg_r.audio_managed        <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (idx)
      pps_pkg::REG_USER_MODE:        cfg_prdata[1:0] = cfg_r.op_mode;
      pps_pkg::REG_LOW_BAT_PERCENT:  cfg_prdata[6:0] = cfg_r.low_battery_percent;
      pps_pkg::REG_BAT_FREQ_CAP:     cfg_prdata[6:0] = cfg_r.battery_freq_cap;
      pps_pkg::REG_LOW_BAT_FREQ_CAP: cfg_prdata[6:0] = cfg_r.low_battery_freq_cap;
      pps_pkg::REG_CUSTOM_ALLOW:     cfg_prdata[0]   = cfg_r.custom_allow_perf;
      pps_pkg::REG_CUSTOM_RPM_AGGR:  cfg_prdata[0]   = cfg_r.custom_runtime_aggr;
      pps_pkg::REG_WIFI_MANAGED:     cfg_prdata[0]   = cfg_r.wifi_managed;
      pps_pkg::REG_AUDIO_MANAGED:    cfg_prdata[0]   = cfg_r.audio_managed;
      default: ;
    endcase
  end

endmodule

// ===== rtl/pps_decide.sv =====
// Decision logic that maps one supply status item to a policy result.
module pps_decide (
  input  pps_pkg::cfg_t    cfg,
  input  pps_pkg::status_t status,
  output pps_pkg::policy_t policy
);

  function automatic logic [1:0] aggr_level(input pps_pkg::mode_t mode,
                                            input pps_pkg::gov_state_t gs,
                                            input logic on, input logic low,
                                            input logic allow);
    logic [1:0] lvl;
    if (!on) begin
      lvl = pps_pkg::AggrNone;
    end else if (low) begin
      lvl = pps_pkg::AggrMax;
    end else if (allow && (mode == pps_pkg::MODE_PERFORMANCE ||
                           gs == pps_pkg::GS_PERFORMANCE)) begin
      lvl = pps_pkg::AggrNone;
    end else if (gs == pps_pkg::GS_POWERSAVE || mode == pps_pkg::MODE_MAX_BATTERY) begin
      lvl = pps_pkg::AggrHigh;
    end else begin
      lvl = pps_pkg::AggrLow;
    end
    return lvl;
  endfunction

  logic       on;
  logic       low;
  logic       allow;
  logic       periph_en;
  logic [1:0] aggr_base;
  logic [1:0] aggr;

  assign on        = status.supply_present & status.source_battery;
  // A negative charge is unknown and never counts as low.
  assign low       = on & ~status.capacity_percent[7] &
                     (status.capacity_percent[6:0] <= cfg.low_battery_percent);
  assign periph_en = cfg.wifi_managed | cfg.audio_managed;

  always_comb begin
    priority if (cfg.op_mode == pps_pkg::MODE_CUSTOM) begin
      allow = cfg.custom_allow_perf;
    end else if (cfg.op_mode == pps_pkg::MODE_PERFORMANCE) begin
      allow = 1'b1;
    end else if (status.perf_limited || low) begin
      allow = 1'b0;
    end else begin
      allow = ~on;
    end
  end

  assign aggr_base = aggr_level(cfg.op_mode, status.governor_state, on, low, allow);

  always_comb begin
    aggr = aggr_base;
    // Custom mode on battery keeps peripherals managed at least at the lowest level.
    if (cfg.op_mode == pps_pkg::MODE_CUSTOM && periph_en && aggr_base == pps_pkg::AggrNone)
    begin
      aggr = pps_pkg::AggrLow;
    end
  end

  always_comb begin
    policy = '0;
    unique case (status.governor_state)
      pps_pkg::GS_POWERSAVE: begin
        policy.governor_sel = pps_pkg::GOV_POWERSAVE;
        policy.energy_pref  = pps_pkg::EPP_POWER;
        policy.turbo_enable = 1'b0;
      end
      pps_pkg::GS_BALANCED: begin
        policy.governor_sel = pps_pkg::GOV_SCHEDUTIL;
        policy.energy_pref  = on ? pps_pkg::EPP_BAL_POWER : pps_pkg::EPP_BAL_PERF;
        policy.turbo_enable = ~on;
      end
      pps_pkg::GS_PERFORMANCE: begin
        if (allow) begin
          policy.governor_sel = pps_pkg::GOV_PERFORMANCE;
          policy.energy_pref  = pps_pkg::EPP_PERFORMANCE;
          policy.turbo_enable = 1'b1;
        end else begin
          policy.governor_sel = pps_pkg::GOV_SCHEDUTIL;
          policy.energy_pref  = on ? pps_pkg::EPP_BAL_POWER : pps_pkg::EPP_BAL_PERF;
          policy.turbo_enable = ~on;
        end
      end
      pps_pkg::GS_OTHER: begin
        policy.governor_sel = pps_pkg::GOV_SCHEDUTIL;
        policy.energy_pref  = pps_pkg::EPP_DEFAULT;
        policy.turbo_enable = 1'b1;
      end
      default: ;
    endcase

    policy.perf_allowed = allow;

    if (!on) begin
      policy.freq_cap_percent = '0;
      policy.runtime_pm_aggr  = 1'b0;
      policy.dev_aggr_level   = pps_pkg::AggrNone;
      if (cfg.op_mode == pps_pkg::MODE_CUSTOM) begin
        policy.sys_profile = allow ? pps_pkg::PROF_PERFORMANCE : pps_pkg::PROF_BALANCED;
      end else begin
        policy.sys_profile = (status.governor_state == pps_pkg::GS_PERFORMANCE) ?
                             pps_pkg::PROF_PERFORMANCE : pps_pkg::PROF_BALANCED;
      end
    end else begin
      policy.dev_aggr_level = aggr;
      if (cfg.op_mode == pps_pkg::MODE_CUSTOM) begin
        policy.freq_cap_percent = cfg.battery_freq_cap;
        policy.sys_profile      = pps_pkg::PROF_BALANCED;
        policy.runtime_pm_aggr  = cfg.custom_runtime_aggr;
      end else begin
        priority if (low) begin
          policy.freq_cap_percent = cfg.low_battery_freq_cap;
          policy.sys_profile      = pps_pkg::PROF_LOW_POWER;
          policy.runtime_pm_aggr  = 1'b1;
        end else if (cfg.op_mode == pps_pkg::MODE_BALANCED) begin
          policy.freq_cap_percent = cfg.battery_freq_cap;
          policy.sys_profile      = pps_pkg::PROF_BALANCED;
          policy.runtime_pm_aggr  = 1'b1;
        end else begin
          policy.freq_cap_percent = '0;
          policy.sys_profile      = pps_pkg::PROF_BALANCED;
          policy.runtime_pm_aggr  = aggr[1];
        end
      end
      if (aggr == pps_pkg::AggrNone || !periph_en) begin
        policy.periph_pm_lvl = pps_pkg::PeriphOff;
      end else if (aggr == pps_pkg::AggrMax) begin
        policy.periph_pm_lvl = pps_pkg::PeriphHigh;
      end else begin
        policy.periph_pm_lvl = pps_pkg::PeriphLow;
      end
    end
  end

endmodule

// ===== rtl/power_policy_select_core.sv =====
// Top level of the power policy selector: input and result registers around the decision logic.
//
//   channel | role     | tdata fields (low bit first)
//   in_     | status   | supply_present, source_battery, capacity_percent,
//           |          | governor_state, perf_limited
//   out_    | policy   | governor_sel .. periph_pm_lvl
//   cfg_    | register | eight policy registers at 4-byte strides
//
// Each status transfer produces one policy transfer, and one transfer per
// cycle is sustained while out_tready stays high. The input register and the
// result register form a two-deep pipeline; the decision logic sits between
// them. A stall on out_tready holds the result register and lets the input
// register fill once before in_tready drops. Reset clears the valid flags and
// loads the register defaults.
module power_policy_select_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [0] supply_present, [1] source_battery, [9:2] capacity_percent,
  // [11:10] governor_state, [12] perf_limited, [15:13] zero
  input  logic [pps_pkg::InDataW-1:0]  in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [1:0] governor_sel, [4:2] energy_pref, [5] turbo_enable, [6] perf_allowed,
  // [13:7] freq_cap_percent, [15:14] sys_profile, [16] runtime_pm_aggr,
  // [18:17] dev_aggr_level, [20:19] periph_pm_lvl, [23:21] zero
  output logic [pps_pkg::OutDataW-1:0] out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pps_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [pps_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [pps_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  pps_pkg::cfg_t    cfg;
  pps_pkg::status_t status_r;
  pps_pkg::policy_t policy_nxt;
  pps_pkg::policy_t policy_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             out_adv;
  logic             in_take;

  pps_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pps_decide u_decide (
    .cfg    (cfg),
    .status (status_r),
    .policy (policy_nxt)
  );

  // The result register can load whenever it is empty or being drained.
  assign out_adv   = ~out_valid_r | out_tready;
  assign in_tready = ~in_valid_r | out_adv;
  assign in_take   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      status_r.supply_present   <= in_tdata[0];
      status_r.source_battery   <= in_tdata[1];
      status_r.capacity_percent <= in_tdata[9:2];
      status_r.governor_state   <= pps_pkg::gov_state_t'(in_tdata[11:10]);
      status_r.perf_limited     <= in_tdata[12];
    end
    if (out_adv && in_valid_r) begin
      policy_r <= policy_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       policy_r.periph_pm_lvl,
                       policy_r.dev_aggr_level,
                       policy_r.runtime_pm_aggr,
                       policy_r.sys_profile,
                       policy_r.freq_cap_percent,
                       policy_r.perf_allowed,
                       policy_r.turbo_enable,
                       policy_r.energy_pref,
                       policy_r.governor_sel};

endmodule
